// ===== src/dde_pkg.sv =====
package dde_pkg;

    // Field widths fixed by the item format.
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned DIGIT_W = 6;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned LVL_W   = 4;
    localparam int unsigned KEY_W   = 8;

    // Field geometry constants.
    localparam logic [POS_W-1:0] MAX_DIGITS = 4'd9;
    localparam logic [LVL_W-1:0] TOP_LEVEL  = 4'd8;

    // Key codes that count as digits.
    localparam logic [KEY_W-1:0] KEY_ZERO = 8'h30;
    localparam logic [KEY_W-1:0] KEY_NINE = 8'h39;

    localparam logic [DIGIT_W-1:0] DIGIT_NINE = 6'd9;

    // Register index, taken from paddr[2].
    localparam logic REG_DIGIT_COUNT  = 1'b0;
    localparam logic REG_DOT_POSITION = 1'b1;

    typedef enum logic [1:0] {
        REQ_READ,
        REQ_UP,
        REQ_DOWN,
        REQ_KEY
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXTRACT,
        ST_ADJUST,
        ST_DONE
    } state_t;

    // Work handed from the slot decoder to the sequencer.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [LVL_W-1:0]   level;
        req_t               req;
        logic [KEY_W-1:0]   key;
        logic               is_dot;
        logic               is_exit;
    } job_t;

    // Finished item returned by the sequencer.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [DIGIT_W-1:0] digit;
        logic               is_dot;
        logic               is_exit;
    } result_t;

    // Power of ten for a digit position; positions above the top map to the top.
    function automatic logic [VALUE_W-1:0] pow_ten(input logic [LVL_W-1:0] lvl);
        logic [VALUE_W-1:0] p;
        case (lvl)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            default: p = 32'd100000000;
        endcase
        return p;
    endfunction

endpackage

// ===== src/dde_addsub.sv =====
module dde_addsub
    import dde_pkg::*;
(
    input  logic [VALUE_W-1:0] a,
    input  logic [VALUE_W-1:0] b,
    input  logic               sub,
    output logic [VALUE_W-1:0] sum,
    output logic               carry
);

    logic [VALUE_W-1:0] b_in;
    logic [VALUE_W:0]   total;

    // Two's complement subtract; on a subtract, carry high means a >= b.
    assign b_in  = sub ? ~b : b;
    assign total = {1'b0, a} + {1'b0, b_in} + {{VALUE_W{1'b0}}, sub};
    assign sum   = total[VALUE_W-1:0];
    assign carry = total[VALUE_W];

endmodule

// ===== src/dde_core.sv =====
module dde_core
    import dde_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  job_t    job,
    output logic    idle,
    output logic    done,
    input  logic    take,
    output result_t result
);

    state_t state_reg, state_next;

    logic [VALUE_W-1:0] rem_reg, rem_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    logic [LVL_W-1:0]   pos_reg, pos_next;
    logic [DIGIT_W-1:0] cnt_reg, cnt_next;
    logic [DIGIT_W-1:0] digit_reg, digit_next;
    logic               dir_up_reg, dir_up_next;
    req_t               req_reg, req_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               is_dot_reg, is_dot_next;
    logic               is_exit_reg, is_exit_next;

    logic [VALUE_W-1:0] alu_a;
    logic [VALUE_W-1:0] alu_b;
    logic               alu_sub;
    logic [VALUE_W-1:0] alu_sum;
    logic               alu_carry;

    logic               key_ok;
    logic [DIGIT_W-1:0] key_digit;
    logic [DIGIT_W-1:0] new_digit;
    logic               adj_up;
    logic [DIGIT_W-1:0] adj_count;

    // The one add/subtract unit: compares and strips powers of ten from the
    // remainder, then steps the value by the power of ten at the digit.
    assign alu_a   = (state_reg == ST_ADJUST) ? acc_reg : rem_reg;
    assign alu_b   = pow_ten(lvl_reg);
    assign alu_sub = (state_reg == ST_ADJUST) ? !dir_up_reg : 1'b1;

    dde_addsub u_addsub (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    // Target digit, worked out from the digit count held in cnt_reg.
    assign key_ok    = (key_reg >= KEY_ZERO) && (key_reg <= KEY_NINE);
    assign key_digit = DIGIT_W'(key_reg - KEY_ZERO);

    always_comb
    begin
        case (req_reg)
            REQ_UP:   new_digit = (cnt_reg < DIGIT_NINE) ? cnt_reg + 1'b1 : '0;
            REQ_DOWN: new_digit = (cnt_reg != '0) ? cnt_reg - 1'b1 : DIGIT_NINE;
            REQ_KEY:  new_digit = key_ok ? key_digit : cnt_reg;
            default:  new_digit = cnt_reg;
        endcase
    end

    // The change is applied as a run of single steps up or down.
    assign adj_up    = new_digit > cnt_reg;
    assign adj_count = adj_up ? new_digit - cnt_reg : cnt_reg - new_digit;

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        acc_reg     <= acc_next;
        lvl_reg     <= lvl_next;
        pos_reg     <= pos_next;
        cnt_reg     <= cnt_next;
        digit_reg   <= digit_next;
        dir_up_reg  <= dir_up_next;
        req_reg     <= req_next;
        key_reg     <= key_next;
        is_dot_reg  <= is_dot_next;
        is_exit_reg <= is_exit_next;
    end

    // Next state and datapath control.
    always_comb
    begin
        state_next   = state_reg;
        rem_next     = rem_reg;
        acc_next     = acc_reg;
        lvl_next     = lvl_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        digit_next   = digit_reg;
        dir_up_next  = dir_up_reg;
        req_next     = req_reg;
        key_next     = key_reg;
        is_dot_next  = is_dot_reg;
        is_exit_next = is_exit_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rem_next     = job.value;
                    acc_next     = job.value;
                    lvl_next     = TOP_LEVEL;
                    pos_next     = job.level;
                    cnt_next     = '0;
                    digit_next   = '0;
                    req_next     = job.req;
                    key_next     = job.key;
                    is_dot_next  = job.is_dot;
                    is_exit_next = job.is_exit;
                    state_next   = (job.is_dot || job.is_exit) ? ST_DONE : ST_EXTRACT;
                end
            end

            // Count how often the power of ten fits, top position downward.
            ST_EXTRACT:
            begin
                if (alu_carry)
                begin
                    rem_next = alu_sum;
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (lvl_reg == pos_reg)
                begin
                    digit_next  = cnt_reg;
                    cnt_next    = adj_count;
                    dir_up_next = adj_up;
                    state_next  = ST_ADJUST;
                end
                else
                begin
                    lvl_next = lvl_reg - 1'b1;
                    cnt_next = '0;
                end
            end

            // Step the value toward the new digit, wrapping modulo 2^32.
            ST_ADJUST:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    acc_next = alu_sum;
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle           = (state_reg == ST_IDLE);
    assign done           = (state_reg == ST_DONE);
    assign result.value   = acc_reg;
    assign result.digit   = digit_reg;
    assign result.is_dot  = is_dot_reg;
    assign result.is_exit = is_exit_reg;

endmodule

// ===== src/decimal_digit_editor_top.sv =====
// Channel  Direction  Signals                         Contents
// s_       in         tvalid tready tdata[47:0] tuser  one edit request
// m_       out        tvalid tready tdata[39:0] tuser  edited value and slot digit
// apb      in/out     psel penable pwrite paddr ...    digit_count, dot_position
//
// Dot and exit slots go from acceptance straight to the done state and from there
// into the output register. A digit slot first runs the extract and adjust states
// on the one shared add/subtract unit. s_tready is high only while the sequencer
// is idle; a finished item waits in the output register while the next one is
// accepted, and the sequencer holds it while m_ stalls.
// Reset sets digit_count to 9 and dot_position to 0.
module decimal_digit_editor_top
    import dde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // current_value[31:0], char_position[35:32], key_code[43:36]
    input  logic [1:0]  s_tuser,   // req_type[1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // new_value[31:0], digit_value[37:32]
    output logic [1:0]  m_tuser,   // is_dot[0], is_exit[1]

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [POS_W-1:0] digit_count_reg;
    logic [POS_W-1:0] dot_position_reg;

    logic [POS_W-1:0] digits;
    logic [POS_W-1:0] dot;
    logic [POS_W-1:0] size;
    logic [POS_W-1:0] slot;
    logic [POS_W-1:0] rpos;
    logic [POS_W-1:0] level;
    logic             slot_exit;
    logic             slot_dot;

    job_t    job;
    result_t result;
    logic    core_idle;
    logic    core_done;
    logic    start;
    logic    load;

    logic          m_tvalid_reg;
    result_t       out_reg;

    // Configuration registers.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg  <= MAX_DIGITS;
            dot_position_reg <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == REG_DIGIT_COUNT)
            begin
                digit_count_reg <= pwdata[POS_W-1:0];
            end
            else
            begin
                dot_position_reg <= pwdata[POS_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_DOT_POSITION) ? {28'd0, dot_position_reg}
                                                   : {28'd0, digit_count_reg};

    // Map the character slot to a digit position, the dot or the exit.
    always_comb
    begin
        if (digit_count_reg == '0)
        begin
            digits = 4'd1;
        end
        else if (digit_count_reg > MAX_DIGITS)
        begin
            digits = MAX_DIGITS;
        end
        else
        begin
            digits = digit_count_reg;
        end

        dot       = (dot_position_reg > digits) ? '0 : dot_position_reg;
        size      = digits + {3'd0, dot != '0};
        slot      = s_tdata[35:32];
        slot_exit = slot >= size;
        rpos      = size - 1'b1 - slot;
        slot_dot  = !slot_exit && (dot != '0) && (rpos == dot);

        if ((dot != '0) && (rpos > dot))
        begin
            level = rpos - 1'b1;
        end
        else
        begin
            level = rpos;
        end

        if (level > TOP_LEVEL)
        begin
            level = TOP_LEVEL;
        end
    end

    assign job.value   = s_tdata[31:0];
    assign job.level   = level;
    assign job.req     = req_t'(s_tuser);
    assign job.key     = s_tdata[43:36];
    assign job.is_dot  = slot_dot;
    assign job.is_exit = slot_exit;

    assign s_tready = core_idle;
    assign start    = s_tvalid && s_tready;

    dde_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .job    (job),
        .idle   (core_idle),
        .done   (core_done),
        .take   (load),
        .result (result)
    );

    // Output register decouples the sequencer from the downstream stall.
    assign load = core_done && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'd0, out_reg.digit, out_reg.value};
    assign m_tuser  = {out_reg.is_exit, out_reg.is_dot};

endmodule

// ===== sim/decimal_digit_editor_top_tb.sv =====
module decimal_digit_editor_top_tb;
    import dde_pkg::*;

    localparam logic [VALUE_W-1:0] TOP_SCALE = 32'd100000000;
    localparam int unsigned LONG_HOLD = 400;

    // One edit request as the driver offers it.
    typedef struct {
        req_t              req;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   pos;
        logic [KEY_W-1:0]   key;
        int unsigned        gap;
    } edit_req_t;

    // Result the block should return for one request.
    typedef struct {
        req_t               req;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
        logic [DIGIT_W-1:0] digit;
        logic               is_dot;
        logic               is_exit;
    } edit_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // current_value[31:0], char_position[35:32], key_code[43:36]
    logic [1:0]  s_tuser = '0;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // new_value[31:0], digit_value[37:32]
    logic [1:0]  m_tuser;        // is_dot[0], is_exit[1]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Register mirror, reset values of the block.
    logic [3:0] digit_count_cfg = 4'd9;
    logic [3:0] dot_position_cfg = 4'd0;

    edit_req_t    pending_edits[$];
    edit_result_t expected_edits[$];
    edit_req_t    cur_edit;

    int unsigned send_gap = 0;
    int unsigned recv_wait = 0;
    int unsigned recv_hold_left = 0;
    logic        hold_request = 1'b0;
    logic        recv_idle_on = 1'b1;

    int unsigned errors = 0;
    int unsigned n_accepted = 0;
    int unsigned n_digit_slots = 0;
    int unsigned n_dot_slots = 0;
    int unsigned n_exit_slots = 0;
    int unsigned n_settings = 0;

    decimal_digit_editor_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Effective field geometry: digit count clamped to 1..9, dot dropped when too far left.
    function automatic void field_layout(input logic [3:0] dc, input logic [3:0] dp,
                                         output int unsigned digits, output int unsigned dot);
        digits = dc;
        if (digits == 0)
            digits = 1;
        if (digits > 9)
            digits = 9;
        dot = dp;
        if (dot > digits)
            dot = 0;
    endfunction

    // Expected result of one edit request under the given register values.
    function automatic edit_result_t predict_edit(input edit_req_t it, input logic [3:0] dc,
                                                  input logic [3:0] dp);
        int unsigned        digits, dot, size, r, p, i;
        logic [VALUE_W-1:0] scale, d, k, nv;
        edit_result_t       res;

        field_layout(dc, dp, digits, dot);
        size = digits + ((dot != 0) ? 1 : 0);
        res.req = it.req;
        res.pos = it.pos;
        res.value = it.value;
        res.digit = '0;
        res.is_dot = 1'b0;
        res.is_exit = 1'b0;
        if (it.pos >= size)
        begin
            res.is_exit = 1'b1;
            return res;
        end
        r = size - 1 - it.pos;
        if (dot != 0 && r == dot)
        begin
            res.is_dot = 1'b1;
            return res;
        end
        p = (dot != 0 && r > dot) ? r - 1 : r;
        if (p > 8)
            p = 8;
        scale = 32'd1;
        for (i = 0; i < p; i++)
            scale = scale * 32'd10;
        // The top position keeps everything above it, so it can read up to 42.
        if (p == 8)
            d = it.value / TOP_SCALE;
        else
            d = (it.value / scale) % 32'd10;
        nv = it.value;
        case (it.req)
            REQ_UP:
                nv = (d < 9) ? it.value + scale : it.value - d * scale;
            REQ_DOWN:
                nv = (d > 0) ? it.value - scale : it.value + 32'd9 * scale;
            REQ_KEY:
                if (it.key >= KEY_ZERO && it.key <= KEY_NINE)
                begin
                    k = {24'd0, it.key - KEY_ZERO};
                    nv = it.value - d * scale + k * scale;
                end
            default:
                nv = it.value;
        endcase
        res.value = nv;
        res.digit = d[DIGIT_W-1:0];
        return res;
    endfunction

    // Driver: offers pending items, records the expected result on each handshake.
    always @(posedge clk)
    begin : driver
        edit_result_t want;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                want = predict_edit(cur_edit, digit_count_cfg, dot_position_cfg);
                expected_edits.push_back(want);
                n_accepted++;
                if (want.is_exit)
                    n_exit_slots++;
                else if (want.is_dot)
                    n_dot_slots++;
                else
                    n_digit_slots++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_edits.size() != 0)
                begin
                    cur_edit = pending_edits.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {4'b0, cur_edit.key, cur_edit.pos, cur_edit.value};
                    s_tuser <= cur_edit.req;
                    send_gap <= cur_edit.gap;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold, counted here so the monitor only has to look at it.
    always @(posedge clk)
    begin
        if (hold_request)
            recv_hold_left <= LONG_HOLD;
        else if (recv_hold_left != 0)
            recv_hold_left <= recv_hold_left - 1;
    end

    // Monitor: compares each returned item with the oldest expectation.
    always @(posedge clk)
    begin : monitor
        edit_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_edits.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Unexpected result: value %h digit %0d dot %b exit %b",
                                 m_tdata[31:0], m_tdata[37:32], m_tuser[0], m_tuser[1]);
                end
                else
                begin
                    want = expected_edits.pop_front();
                    if (m_tdata[31:0] !== want.value || m_tdata[37:32] !== want.digit
                        || m_tuser[0] !== want.is_dot || m_tuser[1] !== want.is_exit)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("Mismatch for %s at slot %0d: expected value %h digit %0d",
                                     want.req.name(), want.pos, want.value, want.digit);
                            $display("  expected dot %b exit %b, got value %h digit %0d",
                                     want.is_dot, want.is_exit, m_tdata[31:0], m_tdata[37:32]);
                            $display("  got dot %b exit %b", m_tuser[0], m_tuser[1]);
                        end
                    end
                end
                recv_wait = recv_idle_on ? $urandom_range(0, 7) : 0;
            end
            if (recv_hold_left != 0)
                m_tready <= 1'b0;
            else if (recv_wait != 0)
            begin
                m_tready <= 1'b0;
                recv_wait--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic queue_edit(input req_t req, input logic [31:0] value, input logic [3:0] pos,
                              input logic [7:0] key, input bit send_idle);
        edit_req_t it;
        it.req = req;
        it.value = value;
        it.pos = pos;
        it.key = key;
        it.gap = send_idle ? $urandom_range(0, 7) : 0;
        pending_edits.push_back(it);
    endtask

    // Setup cycle then access cycle; the register takes the value on the access edge.
    task automatic write_reg(input logic idx, input logic [3:0] val);
        logic [31:0] noise;
        noise = $urandom;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {noise[31:4], val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_DIGIT_COUNT)
            digit_count_cfg = val;
        else
            dot_position_cfg = val;
    endtask

    // Returns at a falling edge once every item is taken and every result is back.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_edits.size() != 0 || s_tvalid || expected_edits.size() != 0);
    endtask

    // Random items for the current register values, mostly on slots inside the field.
    task automatic queue_random(input int unsigned count, input bit send_idle);
        int unsigned   digits, dot, size, n;
        logic [31:0]   value;
        logic [3:0]    pos;
        logic [7:0]    key;
        field_layout(digit_count_cfg, dot_position_cfg, digits, dot);
        size = digits + ((dot != 0) ? 1 : 0);
        for (n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 5))
                0: value = $urandom_range(0, 9999);
                1: value = $urandom_range(0, 999999999);
                2: value = 32'hFFFFFFFF - $urandom_range(0, 300000000);
                3: value = $urandom_range(0, 9) * TOP_SCALE + $urandom_range(0, 99999999);
                default: value = $urandom;
            endcase
            if ($urandom_range(0, 4) != 0)
                pos = 4'($urandom_range(0, size));
            else
                pos = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 3) != 0)
                key = KEY_ZERO + 8'($urandom_range(0, 9));
            else
                key = 8'($urandom_range(0, 255));
            queue_edit(req_t'($urandom_range(0, 3)), value, pos, key, send_idle);
        end
    endtask

    // One register setting: write both registers while idle, run items, drain.
    task automatic run_setting(input logic [3:0] dc, input logic [3:0] dp,
                               input int unsigned count, input bit send_idle,
                               input bit recv_idle, input bit long_hold);
        wait_idle();
        recv_idle_on = recv_idle;
        write_reg(REG_DIGIT_COUNT, dc);
        write_reg(REG_DOT_POSITION, dp);
        n_settings++;
        if (long_hold)
        begin
            @(posedge clk);
            hold_request <= 1'b1;
            @(posedge clk);
            hold_request <= 1'b0;
        end
        queue_random(count, send_idle);
        wait_idle();
    endtask

    initial
    begin
        int unsigned n;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: nine digits, no dot. Top digit, wraps, keys and exit slots.
        queue_edit(REQ_READ, 32'hFFFFFFFF, 4'd0, KEY_ZERO, 1'b1);
        queue_edit(REQ_UP, 32'hFFFFFFFF, 4'd0, KEY_ZERO, 1'b1);
        queue_edit(REQ_UP, 32'd850000000, 4'd0, KEY_ZERO, 1'b1);
        queue_edit(REQ_UP, 32'd950000000, 4'd0, KEY_ZERO, 1'b1);
        queue_edit(REQ_DOWN, 32'd0, 4'd0, KEY_ZERO, 1'b1);
        queue_edit(REQ_DOWN, 32'd0, 4'd8, KEY_ZERO, 1'b1);
        queue_edit(REQ_UP, 32'hFFFFFFFF, 4'd8, KEY_ZERO, 1'b1);
        queue_edit(REQ_KEY, 32'hFFFFFFFF, 4'd8, KEY_NINE, 1'b1);
        queue_edit(REQ_KEY, 32'd123456789, 4'd3, KEY_ZERO, 1'b1);
        queue_edit(REQ_KEY, 32'd123456789, 4'd4, KEY_ZERO - 8'd1, 1'b1);
        queue_edit(REQ_KEY, 32'd123456789, 4'd4, KEY_NINE + 8'd1, 1'b1);
        queue_edit(REQ_KEY, 32'd123456789, 4'd4, 8'hFF, 1'b1);
        queue_edit(REQ_UP, 32'd5, 4'd9, KEY_ZERO, 1'b1);
        queue_edit(REQ_DOWN, 32'd5, 4'd15, KEY_ZERO, 1'b1);
        run_setting(4'd9, 4'd0, 70, 1'b1, 1'b1, 1'b0);

        // Four digits with the dot two from the right: dot slot, exit slot, both sides.
        wait_idle();
        write_reg(REG_DIGIT_COUNT, 4'd4);
        write_reg(REG_DOT_POSITION, 4'd2);
        queue_edit(REQ_UP, 32'd1234, 4'd2, KEY_ZERO, 1'b1);
        queue_edit(REQ_KEY, 32'd1234, 4'd2, KEY_ZERO + 8'd5, 1'b1);
        queue_edit(REQ_READ, 32'd1234, 4'd5, KEY_ZERO, 1'b1);
        queue_edit(REQ_DOWN, 32'd0, 4'd0, KEY_ZERO, 1'b1);
        queue_edit(REQ_KEY, 32'd1234, 4'd4, KEY_ZERO + 8'd7, 1'b1);
        queue_edit(REQ_UP, 32'd9999, 4'd1, KEY_ZERO, 1'b1);
        run_setting(4'd4, 4'd2, 70, 1'b1, 1'b1, 1'b0);

        // Clamping extremes, dot at the far left, long output stall, back-to-back traffic.
        run_setting(4'd0, 4'd0, 50, 1'b1, 1'b0, 1'b0);
        run_setting(4'd15, 4'd15, 60, 1'b0, 1'b1, 1'b0);
        run_setting(4'd9, 4'd9, 70, 1'b1, 1'b1, 1'b0);
        run_setting(4'd3, 4'd3, 50, 1'b1, 1'b1, 1'b1);
        run_setting(4'd1, 4'd1, 40, 1'b0, 1'b0, 1'b0);
        run_setting(4'd9, 4'd8, 60, 1'b1, 1'b1, 1'b0);
        for (n = 0; n < 4; n++)
            run_setting(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 55,
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);

        // Let any stray result show up before closing.
        wait_idle();
        repeat (150) @(posedge clk);
        if (expected_edits.size() != 0)
            errors += expected_edits.size();

        $display("Ran %0d edit requests under %0d register settings:", n_accepted, n_settings);
        $display("  %0d on digit slots, %0d on the dot, %0d on or past the exit; %0d mismatches.",
                 n_digit_slots, n_dot_slots, n_exit_slots, errors);
        if (errors == 0)
            $display("decimal_digit_editor_top_tb: clean");
        else
            $display("decimal_digit_editor_top_tb: errors");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #(8000000);
        $display("decimal_digit_editor_top_tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/dde_pkg.sv
src/dde_addsub.sv
src/dde_core.sv
src/decimal_digit_editor_top.sv
sim/decimal_digit_editor_top_tb.sv
